>>> rtl/core/array_binary_search_tree_assert.svh
// assertion macros used by the block's checker
`ifndef ARRAY_BINARY_SEARCH_TREE_ASSERT_SVH
`define ARRAY_BINARY_SEARCH_TREE_ASSERT_SVH
// same-cycle implication, checked outside reset
`define ABST_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication, checked outside reset
`define ABST_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

>>> rtl/core/abst_pkg.sv
// shared types and constants of the array binary search tree
package abst_pkg;

  localparam int KIND_W       = 2;
  localparam int KEY_W        = 32;
  localparam int SLOT_W       = 10;
  localparam int STATUS_W     = 3;
  localparam int CNT_W        = 10;
  localparam int LV_W         = 5;
  localparam int LEVELS_DEF   = 10;
  localparam int KEY_BITS_DEF = 32;

  typedef enum logic [1:0] {
    OP_INS  = 2'd0,
    OP_SRCH = 2'd1,
    OP_NBR  = 2'd2
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED = 3'd0,
    ST_DUP      = 3'd1,
    ST_TOODEEP  = 3'd2,
    ST_FOUND    = 3'd3,
    ST_NOTFOUND = 3'd4,
    ST_NBR      = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    S_CLEAR = 2'd0,
    S_IDLE  = 2'd1,
    S_BUSY  = 2'd2
  } state_e;

  // control part of a request travelling down the cell row
  typedef struct packed {
    logic            act;
    op_e             op;
    logic            done;
    status_e         st;
    logic [LV_W-1:0] lv;
    logic            sok;
    logic            pv;
    logic            lfv;
    logic            rtv;
  } ctl_t;

  typedef struct packed {
    status_e           st;
    logic [SLOT_W-1:0] fslot;
    logic [CNT_W-1:0]  cnt;
    logic [KEY_W-1:0]  pk;
    logic              pv;
    logic [KEY_W-1:0]  lk;
    logic              lfv;
    logic [KEY_W-1:0]  rk;
    logic              rtv;
  } res_t;

endpackage

>>> rtl/core/abst_ram.sv
// generic single-write, single-read ram with registered read data
module abst_ram #(
  parameter int W = 8,
  parameter int D = 2,
  parameter int AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [W-1:0]  wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [W-1:0]  rdata_o
);
  logic [W-1:0] mem_q [D];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

>>> rtl/core/abst_cell.sv
// one tree level: slot storage in sibling pairs plus one request stage
module abst_cell #(
  parameter int LVL = 0,
  parameter int LEVELS = abst_pkg::LEVELS_DEF,
  parameter int KEY_BITS = abst_pkg::KEY_BITS_DEF,
  parameter int CW = 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  abst_pkg::ctl_t             tok_i,
  input  logic [LEVELS-1:0]          node_i,
  input  logic signed [KEY_BITS-1:0] key_i,
  input  logic [LEVELS-1:0]          snode_i,
  input  logic [LEVELS-1:0]          fslot_i,
  input  logic signed [KEY_BITS-1:0] pk_i,
  input  logic signed [KEY_BITS-1:0] lk_i,
  input  logic signed [KEY_BITS-1:0] rk_i,
  output abst_pkg::ctl_t             tok_o,
  output logic [LEVELS-1:0]          node_o,
  output logic signed [KEY_BITS-1:0] key_o,
  output logic [LEVELS-1:0]          snode_o,
  output logic [LEVELS-1:0]          fslot_o,
  output logic signed [KEY_BITS-1:0] pk_o,
  output logic signed [KEY_BITS-1:0] lk_o,
  output logic signed [KEY_BITS-1:0] rk_o,
  input  logic                       we_i,
  input  logic [LEVELS-1:0]          wnode_i,
  input  logic signed [KEY_BITS-1:0] wkey_i,
  input  logic                       clr_i,
  input  logic [CW-1:0]              crow_i
);
  import abst_pkg::*;

  localparam int ROWS  = (LVL < 2) ? 1 : (1 << (LVL - 1));
  localparam int ROW_W = (LVL < 2) ? 1 : LVL - 1;

  ctl_t                       tok_q;
  logic [LEVELS-1:0]          node_q, snode_q, fslot_q;
  logic signed [KEY_BITS-1:0] key_q, pk_q, lk_q, rk_q;
  logic [LEVELS-1:0]          rnode;
  logic [ROW_W-1:0]           raddr, waddr;
  logic                       wsel, we_ev, we_od;
  logic [KEY_BITS:0]          wdata, rd_ev, rd_od, ent;
  logic                       par_hit, chd_hit;
  logic                       ent_v;
  logic signed [KEY_BITS-1:0] ent_k;

  // read address: walk node, or parent / children of a neighbours query
  always_comb begin
    if (tok_i.op == OP_NBR) begin
      rnode = (tok_i.lv == LV_W'(LVL + 1)) ? (snode_i >> 1) : (snode_i << 1);
    end else begin
      rnode = node_i;
    end
    raddr = (LVL < 2) ? '0 : ROW_W'(rnode >> 1);
  end

  // writes: clearing pass on both halves, or one insert
  always_comb begin
    wsel  = we_i && ((wnode_i >> LVL) == LEVELS'(1));
    waddr = (LVL < 2) ? '0 : (clr_i ? ROW_W'(crow_i) : ROW_W'(wnode_i >> 1));
    wdata = clr_i ? '0 : {1'b1, wkey_i};
    we_ev = clr_i || (wsel && !wnode_i[0]);
    we_od = clr_i || (wsel && wnode_i[0]);
  end

  abst_ram #(.W(KEY_BITS + 1), .D(ROWS)) u_even (
    .clk_i  (clk_i),
    .we_i   (we_ev),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rd_ev)
  );

  abst_ram #(.W(KEY_BITS + 1), .D(ROWS)) u_odd (
    .clk_i  (clk_i),
    .we_i   (we_od),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rd_od)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_i;
    end
  end

  always_ff @(posedge clk_i) begin
    node_q  <= node_i;
    key_q   <= key_i;
    snode_q <= snode_i;
    fslot_q <= fslot_i;
    pk_q    <= pk_i;
    lk_q    <= lk_i;
    rk_q    <= rk_i;
  end

  always_comb begin
    ent     = node_q[0] ? rd_od : rd_ev;
    ent_v   = ent[KEY_BITS];
    ent_k   = ent[KEY_BITS-1:0];
    par_hit = tok_q.sok && (tok_q.lv == LV_W'(LVL + 1));
    chd_hit = tok_q.sok && (LVL > 0) && (LV_W'(LVL) == tok_q.lv + LV_W'(1));
    tok_o   = tok_q;
    node_o  = node_q;
    key_o   = key_q;
    snode_o = snode_q;
    fslot_o = fslot_q;
    pk_o    = pk_q;
    lk_o    = lk_q;
    rk_o    = rk_q;
    if (tok_q.op == OP_NBR) begin
      if (par_hit) begin
        tok_o.pv = snode_q[1] ? rd_od[KEY_BITS] : rd_ev[KEY_BITS];
        pk_o     = snode_q[1] ? rd_od[KEY_BITS-1:0] : rd_ev[KEY_BITS-1:0];
        if (!tok_o.pv) begin
          pk_o = '0;
        end
      end
      if (chd_hit) begin
        tok_o.lfv = rd_ev[KEY_BITS];
        tok_o.rtv = rd_od[KEY_BITS];
        lk_o      = rd_ev[KEY_BITS] ? rd_ev[KEY_BITS-1:0] : '0;
        rk_o      = rd_od[KEY_BITS] ? rd_od[KEY_BITS-1:0] : '0;
      end
    end else if (!tok_q.done) begin
      tok_o.done = 1'b1;
      if (!ent_v) begin
        tok_o.st = (tok_q.op == OP_INS) ? ST_INSERTED : ST_NOTFOUND;
        fslot_o  = (tok_q.op == OP_INS) ? node_q : '0;
      end else if (ent_k == key_q) begin
        tok_o.st = (tok_q.op == OP_INS) ? ST_DUP : ST_FOUND;
        fslot_o  = node_q;
      end else if (LVL == LEVELS - 1) begin
        tok_o.st = (tok_q.op == OP_INS) ? ST_TOODEEP : ST_NOTFOUND;
        fslot_o  = '0;
      end else begin
        tok_o.done = 1'b0;
        node_o     = LEVELS'({node_q, !(key_q < ent_k)});
      end
    end
  end
endmodule

>>> rtl/core/array_binary_search_tree.sv
// array binary search tree: one cell per tree level, a request steps one level per cycle
// a request passes the register of each cell in turn, then the result register or its spare entry
// a new request is taken only once the last one has left the cell row
// reset: a clearing pass over the rows empties every slot, requests stalled
// meanwhile; the result register can hold one finished result while the next one runs
module array_binary_search_tree #(
  parameter int LEVELS = abst_pkg::LEVELS_DEF,
  parameter int KEY_BITS = abst_pkg::KEY_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [abst_pkg::KIND_W-1:0]       kind_i,
  input  logic signed [abst_pkg::KEY_W-1:0] key_i,
  input  logic [abst_pkg::SLOT_W-1:0]       slot_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [abst_pkg::STATUS_W-1:0]     status_o,
  output logic [abst_pkg::SLOT_W-1:0]       found_slot_o,
  output logic [abst_pkg::CNT_W-1:0]        stored_count_o,
  output logic signed [abst_pkg::KEY_W-1:0] parent_key_o,
  output logic                              parent_valid_o,
  output logic signed [abst_pkg::KEY_W-1:0] left_key_o,
  output logic                              left_valid_o,
  output logic signed [abst_pkg::KEY_W-1:0] right_key_o,
  output logic                              right_valid_o
);
  import abst_pkg::*;

  // clearing pass walks the rows of the deepest level; shallower levels wrap
  localparam int CW       = (LEVELS > 3) ? LEVELS - 2 : 1;
  localparam int ROWS_MAX = 1 << (LEVELS - 2);
  localparam int EXT      = (LEVELS > SLOT_W) ? LEVELS : SLOT_W;

  state_e state_q, state_d;
  logic [CW-1:0] clr_q, clr_d;
  logic [CNT_W-1:0] cnt_q;
  logic out_v_q, pend_v_q;
  res_t out_q, pend_q, res;

  // request entry
  logic in_acc, exit_w, ins_we;
  logic [EXT-1:0] s_ext;
  logic [LV_W-1:0] lv;
  logic signed [KEY_BITS-1:0] key_k;

  // cell row, index LEVELS is the output of the deepest cell
  ctl_t                       c_tok   [LEVELS+1];
  logic [LEVELS-1:0]          c_node  [LEVELS+1];
  logic signed [KEY_BITS-1:0] c_key   [LEVELS+1];
  logic [LEVELS-1:0]          c_snode [LEVELS+1];
  logic [LEVELS-1:0]          c_fslot [LEVELS+1];
  logic signed [KEY_BITS-1:0] c_pk    [LEVELS+1];
  logic signed [KEY_BITS-1:0] c_lk    [LEVELS+1];
  logic signed [KEY_BITS-1:0] c_rk    [LEVELS+1];

  assign in_stall_o = (state_q != S_IDLE) || pend_v_q;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign key_k      = KEY_BITS'(key_i);
  assign s_ext      = EXT'(slot_i);

  // level of the queried slot: position of its top set bit
  always_comb begin
    lv = '0;
    for (int i = 0; i < EXT; i++) begin
      if (s_ext[i]) begin
        lv = LV_W'(i);
      end
    end
  end

  always_comb begin
    c_tok[0]       = '0;
    c_tok[0].act   = in_acc;
    c_tok[0].op    = kind_i[1] ? OP_NBR : (kind_i[0] ? OP_SRCH : OP_INS);
    c_tok[0].st    = kind_i[1] ? ST_NBR : ST_NOTFOUND;
    c_tok[0].lv    = lv;
    c_tok[0].sok   = (s_ext != '0) && ((s_ext >> LEVELS) == '0);
    c_node[0]      = LEVELS'(1);
    c_key[0]       = key_k;
    c_snode[0]     = LEVELS'(s_ext);
    c_fslot[0]     = '0;
    c_pk[0]        = '0;
    c_lk[0]        = '0;
    c_rk[0]        = '0;
  end

  // the request leaves the deepest cell; an insert lands in its slot now
  assign exit_w = c_tok[LEVELS].act;
  assign ins_we = exit_w && (c_tok[LEVELS].op == OP_INS) &&
                  (c_tok[LEVELS].st == ST_INSERTED);

  for (genvar g = 0; g < LEVELS; g++) begin : g_cell
    abst_cell #(
      .LVL(g), .LEVELS(LEVELS), .KEY_BITS(KEY_BITS), .CW(CW)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .tok_i  (c_tok[g]),
      .node_i (c_node[g]),
      .key_i  (c_key[g]),
      .snode_i(c_snode[g]),
      .fslot_i(c_fslot[g]),
      .pk_i   (c_pk[g]),
      .lk_i   (c_lk[g]),
      .rk_i   (c_rk[g]),
      .tok_o  (c_tok[g+1]),
      .node_o (c_node[g+1]),
      .key_o  (c_key[g+1]),
      .snode_o(c_snode[g+1]),
      .fslot_o(c_fslot[g+1]),
      .pk_o   (c_pk[g+1]),
      .lk_o   (c_lk[g+1]),
      .rk_o   (c_rk[g+1]),
      .we_i   (ins_we),
      .wnode_i(c_fslot[LEVELS]),
      .wkey_i (c_key[LEVELS]),
      .clr_i  (state_q == S_CLEAR),
      .crow_i (clr_q)
    );
  end

  // result of the request leaving the row, count already updated
  always_comb begin
    res       = '0;
    res.st    = c_tok[LEVELS].st;
    res.fslot = SLOT_W'(c_fslot[LEVELS]);
    res.cnt   = cnt_q + CNT_W'(ins_we);
    res.pk    = KEY_W'(c_pk[LEVELS]);
    res.pv    = c_tok[LEVELS].pv;
    res.lk    = KEY_W'(c_lk[LEVELS]);
    res.lfv   = c_tok[LEVELS].lfv;
    res.rk    = KEY_W'(c_rk[LEVELS]);
    res.rtv   = c_tok[LEVELS].rtv;
  end

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    unique case (state_q)
      S_CLEAR: begin
        clr_d = clr_q + CW'(1);
        if (clr_q == CW'(ROWS_MAX - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_BUSY;
        end
      end
      S_BUSY: begin
        if (exit_w) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      if (ins_we) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
    end
  end

  // output register plus one spare entry for a result finished under stall
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      pend_v_q <= 1'b0;
    end else if (exit_w) begin
      if (out_v_q && out_stall_i) begin
        pend_v_q <= 1'b1;
      end else begin
        out_v_q <= 1'b1;
      end
    end else if (out_v_q && !out_stall_i) begin
      out_v_q  <= pend_v_q;
      pend_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exit_w) begin
      if (out_v_q && out_stall_i) begin
        pend_q <= res;
      end else begin
        out_q <= res;
      end
    end else if (out_v_q && !out_stall_i && pend_v_q) begin
      out_q <= pend_q;
    end
  end

  assign out_valid_o    = out_v_q;
  assign status_o       = out_q.st;
  assign found_slot_o   = out_q.fslot;
  assign stored_count_o = out_q.cnt;
  assign parent_key_o   = out_q.pk;
  assign parent_valid_o = out_q.pv;
  assign left_key_o     = out_q.lk;
  assign left_valid_o   = out_q.lfv;
  assign right_key_o    = out_q.rk;
  assign right_valid_o  = out_q.rtv;
endmodule

>>> rtl/core/abst_checker.sv
// port-level checker of the array binary search tree and its bind
`include "array_binary_search_tree_assert.svh"
module abst_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_stall_o,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic [abst_pkg::STATUS_W-1:0]     status_o,
  input logic [abst_pkg::SLOT_W-1:0]       found_slot_o,
  input logic                              parent_valid_o,
  input logic                              left_valid_o,
  input logic                              right_valid_o
);
  import abst_pkg::*;

  `ABST_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)
  `ABST_ASSERT_NXT(a_one_walk, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)
  `ABST_ASSERT_IMP(a_nbr_noslot, clk_i, rst_ni, out_valid_o && (status_o == ST_NBR), found_slot_o == '0)
  `ABST_ASSERT_IMP(a_miss_noslot, clk_i, rst_ni, out_valid_o && ((status_o == ST_NOTFOUND) || (status_o == ST_TOODEEP)), found_slot_o == '0)
  `ABST_ASSERT_IMP(a_walk_nonbr, clk_i, rst_ni, out_valid_o && (status_o != ST_NBR), !parent_valid_o && !left_valid_o && !right_valid_o)
endmodule

bind array_binary_search_tree abst_checker u_abst_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .status_o      (status_o),
  .found_slot_o  (found_slot_o),
  .parent_valid_o(parent_valid_o),
  .left_valid_o  (left_valid_o),
  .right_valid_o (right_valid_o)
);

>>> bench/tb_top.sv
// self-checking regression bench for the array binary search tree
module tb_top;
  import abst_pkg::*;

  localparam int NUM_SLOTS   = 1 << LEVELS_DEF;
  localparam int RANDOM_REQS = 1125;
  localparam int CYCLE_LIMIT = 600000;
  // kind three carries both bits, the block decodes it as a neighbours read
  localparam logic [KIND_W-1:0] KIND_ALIAS = 2'd3;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  logic [KIND_W-1:0]        kind_i = '0;
  logic signed [KEY_W-1:0]  key_i = '0;
  logic [SLOT_W-1:0]        slot_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic [STATUS_W-1:0]      status_o;
  logic [SLOT_W-1:0]        found_slot_o;
  logic [CNT_W-1:0]         stored_count_o;
  logic signed [KEY_W-1:0]  parent_key_o;
  logic                     parent_valid_o;
  logic signed [KEY_W-1:0]  left_key_o;
  logic                     left_valid_o;
  logic signed [KEY_W-1:0]  right_key_o;
  logic                     right_valid_o;

  array_binary_search_tree DUT (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow copy of the tree
  logic signed [KEY_W-1:0] shadow_key [NUM_SLOTS];
  bit                      shadow_used [NUM_SLOTS];
  int unsigned             shadow_count;
  logic signed [KEY_W-1:0] held_keys [$];

  res_t pending_results [$];
  bit   failed = 1'b0;
  int   burst_left = 0;

  // walk from the root; returns the hit slot, free_slot gets the empty landing slot
  function automatic int tree_walk(input logic signed [KEY_W-1:0] k, output int free_slot);
    int node;
    int nxt;
    node = 1;
    free_slot = 0;
    for (int lvl = 0; lvl < LEVELS_DEF; lvl++) begin
      if (!shadow_used[node]) begin
        free_slot = node;
        return 0;
      end
      if (shadow_key[node] == k) return node;
      nxt = (k < shadow_key[node]) ? 2 * node : 2 * node + 1;
      if (nxt >= NUM_SLOTS) return 0;
      node = nxt;
    end
    return 0;
  endfunction

  // applies one request to the shadow tree and returns its result
  function automatic res_t tree_apply(input logic [KIND_W-1:0] kind,
                                      input logic signed [KEY_W-1:0] k,
                                      input logic [SLOT_W-1:0] s);
    res_t r;
    int hit;
    int free_slot;
    int sl;
    r = '0;
    sl = int'(s);
    if (kind[1]) begin
      r.st = ST_NBR;
      if (sl != 0) begin
        if ((sl >> 1) != 0 && shadow_used[sl >> 1]) begin
          r.pk = shadow_key[sl >> 1];
          r.pv = 1'b1;
        end
        if (2 * sl < NUM_SLOTS && shadow_used[2 * sl]) begin
          r.lk = shadow_key[2 * sl];
          r.lfv = 1'b1;
        end
        if (2 * sl + 1 < NUM_SLOTS && shadow_used[2 * sl + 1]) begin
          r.rk = shadow_key[2 * sl + 1];
          r.rtv = 1'b1;
        end
      end
    end else begin
      hit = tree_walk(k, free_slot);
      if (kind == OP_SRCH) begin
        r.st = hit != 0 ? ST_FOUND : ST_NOTFOUND;
        r.fslot = SLOT_W'(hit);
      end else if (hit != 0) begin
        r.st = ST_DUP;
        r.fslot = SLOT_W'(hit);
      end else if (free_slot != 0) begin
        shadow_key[free_slot] = k;
        shadow_used[free_slot] = 1'b1;
        shadow_count++;
        held_keys.push_back(k);
        r.st = ST_INSERTED;
        r.fslot = SLOT_W'(free_slot);
      end else begin
        r.st = ST_TOODEEP;
      end
    end
    r.cnt = shadow_count[CNT_W-1:0];
    return r;
  endfunction

  // drives one request, honoring bursts and gaps, and records its expected result
  task automatic send_request(input logic [KIND_W-1:0] kind,
                              input logic signed [KEY_W-1:0] k,
                              input logic [SLOT_W-1:0] s,
                              input bit typed, input status_e st,
                              input int fslot, input int cnt);
    res_t r;
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 14);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    kind_i     <= kind;
    key_i      <= k;
    slot_i     <= s;
    do @(posedge clk_i); while (in_stall_o);
    r = tree_apply(kind, k, s);
    // directed rows carry a hand-written expectation for the main fields
    if (typed) begin
      r.st = st;
      r.fslot = SLOT_W'(fslot);
      r.cnt = CNT_W'(cnt);
    end
    pending_results.push_back(r);
  endtask

  // keys: spread widely, clustered to force duplicates, already held, or extremes
  function automatic logic signed [KEY_W-1:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return $urandom;
    if (r < 65) return $signed($urandom_range(0, 127)) - 64;
    if (r < 90 && held_keys.size() > 0)
      return held_keys[$urandom_range(0, held_keys.size() - 1)];
    case ($urandom_range(0, 3))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return -32'sd1;
      default: return 32'sd0;
    endcase
  endfunction

  // picks a slot near the occupied part of the tree most of the time
  function automatic logic [SLOT_W-1:0] pick_slot();
    if ($urandom_range(0, 2) == 0) return SLOT_W'($urandom_range(0, NUM_SLOTS - 1));
    return SLOT_W'($urandom_range(0, 63));
  endfunction

  typedef struct {
    logic [KIND_W-1:0]       kind;
    logic signed [KEY_W-1:0] k;
    logic [SLOT_W-1:0]       s;
    bit                      typed;
    status_e                 st;
    int                      fslot;
    int                      cnt;
  } stim_row_t;

  // directed table: empty tree, duplicate, a rightmost chain down to the deepest
  // level and one past it, key extremes, neighbours at root, leaf and slot zero
  stim_row_t directed [] = '{
    '{OP_SRCH, 5,   0,    1, ST_NOTFOUND, 0, 0},
    '{OP_NBR,  0,   1,    1, ST_NBR,      0, 0},
    '{OP_INS,  100, 0,    1, ST_INSERTED, 1, 1},
    '{OP_INS,  100, 0,    1, ST_DUP,      1, 1},
    '{OP_INS,  101, 0,    0, ST_INSERTED, 0, 0},
    '{OP_INS,  102, 0,    0, ST_INSERTED, 0, 0},
    '{OP_INS,  103, 0,    0, ST_INSERTED, 0, 0},
    '{OP_INS,  104, 0,    0, ST_INSERTED, 0, 0},
    '{OP_INS,  105, 0,    0, ST_INSERTED, 0, 0},
    '{OP_INS,  106, 0,    0, ST_INSERTED, 0, 0},
    '{OP_INS,  107, 0,    0, ST_INSERTED, 0, 0},
    '{OP_INS,  108, 0,    0, ST_INSERTED, 0, 0},
    '{OP_INS,  109, 0,    1, ST_INSERTED, 1023, 10},
    '{OP_INS,  110, 0,    1, ST_TOODEEP,  0, 10},
    '{OP_INS,  32'sh8000_0000, 0, 1, ST_INSERTED, 2, 11},
    '{OP_INS,  32'sh7fff_ffff, 0, 1, ST_TOODEEP, 0, 11},
    '{OP_INS,  -1,  0,    0, ST_INSERTED, 0, 0},
    '{OP_SRCH, 32'sh8000_0000, 0, 1, ST_FOUND, 2, 12},
    '{OP_SRCH, 32'sh7fff_ffff, 0, 1, ST_NOTFOUND, 0, 12},
    '{OP_NBR,  0,   2,    0, ST_NBR,      0, 0},
    '{OP_NBR,  0,   1023, 0, ST_NBR,      0, 0},
    '{OP_NBR,  0,   0,    1, ST_NBR,      0, 12},
    '{KIND_ALIAS, 0, 1,   0, ST_NBR,      0, 0},
    '{OP_SRCH, 0,   0,    0, ST_NBR,      0, 0}
  };

  // stimulus
  initial begin
    int sent;
    int r;
    logic signed [KEY_W-1:0] base;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed[i])
      send_request(directed[i].kind, directed[i].k, directed[i].s, directed[i].typed,
                   directed[i].st, directed[i].fslot, directed[i].cnt);
    sent = 0;
    while (sent < RANDOM_REQS) begin
      // let the pipe drain once midway
      if (sent >= RANDOM_REQS / 2 && sent < RANDOM_REQS / 2 + 12) begin
        in_valid_i <= 1'b0;
        wait (pending_results.size() == 0);
        @(posedge clk_i);
        sent = RANDOM_REQS / 2 + 12;
      end
      r = $urandom_range(0, 99);
      if (r < 6) begin
        // sorted run digs one branch down toward the too-deep limit
        base = $urandom;
        for (int j = 0; j < 12; j++)
          send_request(OP_INS, base + j, SLOT_W'($urandom), 0, ST_INSERTED, 0, 0);
        sent += 12;
      end else begin
        if (r < 45) send_request(OP_INS, pick_key(), SLOT_W'($urandom), 0, ST_INSERTED, 0, 0);
        else if (r < 75)
          send_request(OP_SRCH, pick_key(), SLOT_W'($urandom), 0, ST_INSERTED, 0, 0);
        else if (r < 95) send_request(OP_NBR, $urandom, pick_slot(), 0, ST_INSERTED, 0, 0);
        else send_request(KIND_ALIAS, $urandom, pick_slot(), 0, ST_INSERTED, 0, 0);
        sent++;
      end
    end
    in_valid_i <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (30) @(posedge clk_i);
    if (!failed) begin
      $display("array_binary_search_tree regression: pass");
    end else begin
      $display("array_binary_search_tree regression: fail");
    end
    $finish;
  end

  // receiver stall pattern: quiet, sparse or heavy stretches
  int stall_mode = 0;
  int stall_age = 0;
  always @(posedge clk_i) begin
    if (stall_age == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_age  <= $urandom_range(20, 120);
    end else begin
      stall_age <= stall_age - 1;
    end
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      default: out_stall_i <= ($urandom_range(0, 4) != 0);
    endcase
  end

  task automatic check_field(input string name, input logic [KEY_W-1:0] expd,
                             input logic [KEY_W-1:0] act);
    if (expd !== act) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, expd, act);
      failed = 1'b1;
    end
  endtask

  // result checker
  always @(posedge clk_i) begin
    res_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with none expected, status %0d", $time, status_o);
        failed = 1'b1;
      end else begin
        e = pending_results.pop_front();
        check_field("status", KEY_W'(e.st), KEY_W'(status_o));
        check_field("found_slot", KEY_W'(e.fslot), KEY_W'(found_slot_o));
        check_field("stored_count", KEY_W'(e.cnt), KEY_W'(stored_count_o));
        check_field("parent_key", e.pk, parent_key_o);
        check_field("parent_valid", KEY_W'(e.pv), KEY_W'(parent_valid_o));
        check_field("left_key", e.lk, left_key_o);
        check_field("left_valid", KEY_W'(e.lfv), KEY_W'(left_valid_o));
        check_field("right_key", e.rk, right_key_o);
        check_field("right_valid", KEY_W'(e.rtv), KEY_W'(right_valid_o));
      end
    end
  end

  // watchdog
  int cycles = 0;
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("array_binary_search_tree regression: fail");
      $finish;
    end
  end

endmodule

>>> array_binary_search_tree.f
+incdir+rtl/core
rtl/core/abst_pkg.sv
rtl/core/abst_ram.sv
rtl/core/abst_cell.sv
rtl/core/array_binary_search_tree.sv
rtl/core/abst_checker.sv
bench/tb_top.sv
